// ===== rtl/ipv4_address_analyzer_unit_macros.svh =====
// Assertion macros shared by the IPv4 address analyser RTL.
`ifndef IPV4_ADDRESS_ANALYZER_UNIT_MACROS_SVH
`define IPV4_ADDRESS_ANALYZER_UNIT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define IPV4AA_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked assertion that also holds during reset.
`define IPV4AA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== rtl/ipv4aa_pkg.sv =====
// Package with the transfer types and constants of the IPv4 address analyser.
`default_nettype none

package ipv4aa_pkg;

  // Address class codes.
  localparam logic [2:0] ClassA = 3'd0;
  localparam logic [2:0] ClassB = 3'd1;
  localparam logic [2:0] ClassC = 3'd2;
  localparam logic [2:0] ClassD = 3'd3;
  localparam logic [2:0] ClassE = 3'd4;

  // Special-range kind codes.
  localparam logic [2:0] KindNone      = 3'd0;
  localparam logic [2:0] KindPrivate   = 3'd1;
  localparam logic [2:0] KindLoopback  = 3'd2;
  localparam logic [2:0] KindLinkLocal = 3'd3;
  localparam logic [2:0] KindMulticast = 3'd4;

  // Special-range networks and their prefix masks.
  localparam logic [31:0] NetPriv192  = 32'hC0A8_0000;
  localparam logic [31:0] NetPriv172  = 32'hAC10_0000;
  localparam logic [31:0] NetPriv10   = 32'h0A00_0000;
  localparam logic [31:0] NetLoop     = 32'h7F00_0000;
  localparam logic [31:0] NetLinkLoc  = 32'hA9FE_0000;
  localparam logic [31:0] NetMcast    = 32'hE000_0000;
  localparam logic [31:0] Pfx4Mask    = 32'hF000_0000;
  localparam logic [31:0] Pfx8Mask    = 32'hFF00_0000;
  localparam logic [31:0] Pfx12Mask   = 32'hFFF0_0000;
  localparam logic [31:0] Pfx16Mask   = 32'hFFFF_0000;

  // Upper bounds of the first octet for classes A to D.
  localparam logic [7:0] ClassALast = 8'd127;
  localparam logic [7:0] ClassBLast = 8'd191;
  localparam logic [7:0] ClassCLast = 8'd223;
  localparam logic [7:0] ClassDLast = 8'd239;

  // Host count given for a non-contiguous mask (prefix taken as zero).
  localparam logic [31:0] HostsPfx0 = 32'hFFFF_FFFE;

  // One input transfer.
  typedef struct packed {
    logic [31:0] address;
    logic [31:0] net_mask;
  } ipv4_in_t;

  // One result transfer.
  typedef struct packed {
    logic [31:0] network_address;
    logic [31:0] broadcast_address;
    logic [31:0] first_host;
    logic [31:0] last_host;
    logic        mask_ok;
    logic [5:0]  prefix_length;
    logic [31:0] host_count;
    logic [2:0]  addr_class;
    logic [2:0]  addr_kind;
  } ipv4_res_t;

endpackage

`default_nettype wire

// ===== rtl/ipv4_address_analyzer_unit.sv =====
// Top level of the IPv4 address analyser: a three-stage pipeline.
//
//  Channel | Direction | Handshake        | Payload
//  --------+-----------+------------------+---------------------------
//  input   | in        | start_i, busy_o  | in_i     (ipv4_in_t)
//  result  | out       | done_o strobe    | result_o (ipv4_res_t)
//
// One transfer is taken in every cycle; busy_o is never raised.
// Each result appears on done_o after the three register stages (mask check
// and byte counts, prefix sum and host addresses, host count).
// Reset clears the stage valid bits only; the payload registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
`default_nettype none

`include "ipv4_address_analyzer_unit_macros.svh"

module ipv4_address_analyzer_unit (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start_i,
  output logic                       busy_o,
  input  wire ipv4aa_pkg::ipv4_in_t  in_i,
  output logic                       done_o,
  output ipv4aa_pkg::ipv4_res_t      result_o
);

  // Number of ones in one byte.
  function automatic logic [3:0] ones8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

  // Stage registers.
  logic        s1_valid_q, s1_valid_d;
  logic [31:0] s1_net_q, s1_brd_q, s1_inv_q;
  logic        s1_ok_q, s1_ok_d;
  logic [3:0]  s1_cnt_q [4];
  logic [2:0]  s1_class_q, s1_class_d, s1_kind_q, s1_kind_d;

  logic        s2_valid_q;
  logic [31:0] s2_net_q, s2_brd_q, s2_first_q, s2_last_q, s2_inv_q;
  logic        s2_ok_q;
  logic [5:0]  s2_pfx_q, s2_pfx_d;
  logic [2:0]  s2_class_q, s2_kind_q;

  logic                  s3_valid_q;
  ipv4aa_pkg::ipv4_res_t s3_res_q, s3_res_d;

  logic [31:0] inv_mask;
  logic [7:0]  first_octet;

  // The pipeline never stalls.
  assign busy_o     = 1'b0;
  assign s1_valid_d = start_i;

  // Stage one: mask contiguity, range decode and per-byte ones count.
  always_comb begin
    inv_mask    = ~in_i.net_mask;
    first_octet = in_i.address[31:24];
    s1_ok_d     = ((inv_mask & (inv_mask + 32'd1)) == 32'd0);

    priority if (first_octet <= ipv4aa_pkg::ClassALast) begin
      s1_class_d = ipv4aa_pkg::ClassA;
    end else if (first_octet <= ipv4aa_pkg::ClassBLast) begin
      s1_class_d = ipv4aa_pkg::ClassB;
    end else if (first_octet <= ipv4aa_pkg::ClassCLast) begin
      s1_class_d = ipv4aa_pkg::ClassC;
    end else if (first_octet <= ipv4aa_pkg::ClassDLast) begin
      s1_class_d = ipv4aa_pkg::ClassD;
    end else begin
      s1_class_d = ipv4aa_pkg::ClassE;
    end

    priority if (((in_i.address & ipv4aa_pkg::Pfx16Mask) == ipv4aa_pkg::NetPriv192) ||
                 ((in_i.address & ipv4aa_pkg::Pfx12Mask) == ipv4aa_pkg::NetPriv172) ||
                 ((in_i.address & ipv4aa_pkg::Pfx8Mask) == ipv4aa_pkg::NetPriv10)) begin
      s1_kind_d = ipv4aa_pkg::KindPrivate;
    end else if ((in_i.address & ipv4aa_pkg::Pfx8Mask) == ipv4aa_pkg::NetLoop) begin
      s1_kind_d = ipv4aa_pkg::KindLoopback;
    end else if ((in_i.address & ipv4aa_pkg::Pfx16Mask) == ipv4aa_pkg::NetLinkLoc) begin
      s1_kind_d = ipv4aa_pkg::KindLinkLocal;
    end else if ((in_i.address & ipv4aa_pkg::Pfx4Mask) == ipv4aa_pkg::NetMcast) begin
      s1_kind_d = ipv4aa_pkg::KindMulticast;
    end else begin
      s1_kind_d = ipv4aa_pkg::KindNone;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_net_q   <= in_i.address & in_i.net_mask;
    s1_brd_q   <= in_i.address | inv_mask;
    s1_inv_q   <= inv_mask;
    s1_ok_q    <= s1_ok_d;
    s1_class_q <= s1_class_d;
    s1_kind_q  <= s1_kind_d;
    for (int b = 0; b < 4; b++) begin
      s1_cnt_q[b] <= ones8(in_i.net_mask[8*b +: 8]);
    end
  end

  // Stage two: prefix length as the sum of the byte counts, host addresses.
  always_comb begin
    s2_pfx_d = ({2'd0, s1_cnt_q[0]} + {2'd0, s1_cnt_q[1]}) +
               ({2'd0, s1_cnt_q[2]} + {2'd0, s1_cnt_q[3]});
    if (!s1_ok_q) begin
      s2_pfx_d = 6'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_net_q   <= s1_net_q;
    s2_brd_q   <= s1_brd_q;
    s2_first_q <= s1_net_q + 32'd1;
    s2_last_q  <= s1_brd_q - 32'd1;
    s2_inv_q   <= s1_inv_q;
    s2_ok_q    <= s1_ok_q;
    s2_pfx_q   <= s2_pfx_d;
    s2_class_q <= s1_class_q;
    s2_kind_q  <= s1_kind_q;
  end

  // Stage three: host count. For a contiguous mask the inverted mask is
  // 2^(32-prefix)-1, so one less gives the usable hosts.
  always_comb begin
    s3_res_d.network_address   = s2_net_q;
    s3_res_d.broadcast_address = s2_brd_q;
    s3_res_d.first_host        = s2_first_q;
    s3_res_d.last_host         = s2_last_q;
    s3_res_d.mask_ok           = s2_ok_q;
    s3_res_d.prefix_length     = s2_pfx_q;
    s3_res_d.addr_class        = s2_class_q;
    s3_res_d.addr_kind         = s2_kind_q;
    if (!s2_ok_q) begin
      s3_res_d.host_count = ipv4aa_pkg::HostsPfx0;
    end else if (s2_inv_q == 32'd0) begin
      s3_res_d.host_count = 32'd1;
    end else begin
      s3_res_d.host_count = s2_inv_q - 32'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_res_q <= s3_res_d;
  end

  // Valid bits travel alongside the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  assign done_o   = s3_valid_q;
  assign result_o = s3_res_q;

  // A result only leaves when an item sat in stage two in the previous cycle.
  `IPV4AA_ASSERT_RST(a_valid_flow, clk_i, rst_ni, s3_valid_q |-> $past(s2_valid_q), "result without a stage-two item")
  // An invalid mask always reports a zero prefix.
  `IPV4AA_ASSERT_RST(a_bad_mask_pfx, clk_i, rst_ni, (done_o && !result_o.mask_ok) |-> (result_o.prefix_length == 6'd0), "invalid mask with non-zero prefix")
  // A full mask gives exactly one host.
  `IPV4AA_ASSERT_RST(a_full_mask_hosts, clk_i, rst_ni, (done_o && (result_o.prefix_length == 6'd32)) |-> (result_o.host_count == 32'd1), "prefix 32 without a single host")
  // The prefix length never exceeds the address width.
  `IPV4AA_ASSERT_RST(a_pfx_range, clk_i, rst_ni, done_o |-> (result_o.prefix_length <= 6'd32), "prefix length out of range")

endmodule

`default_nettype wire
